[rtl/core/mtmq_pkg.sv]
`timescale 1ns / 1ps
package mtmq_pkg;

  // Default sizes.
  localparam int unsigned DefQueueDepth = 64;
  localparam int unsigned DefHandleBits = 16;
  localparam int unsigned TagBits       = 64;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_POST   = 2'd0,
    OP_PROBE  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_ARRIVE = 2'd3
  } op_e;

  // Status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_MATCH  = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

endpackage

[rtl/core/mtmq_ram.sv]
`timescale 1ns / 1ps
module mtmq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/masked_tag_match_queues.sv]
`timescale 1ns / 1ps
// Tag matching queues: an unexpected-message queue and a posted-receive queue, each
// QUEUE_DEPTH entries deep and held in a single-port-read RAM. One request is handled
// at a time and in_ready_o is low while it is worked on. A search reads one entry
// per cycle through the RAM read port for post, probe and cancel; removing an entry from
// the middle moves each younger entry down one place at one entry per cycle. Arrive
// appends without a search. The result is held in an output register, and the next
// request is taken while it waits. Both queues are empty after reset.
module masked_tag_match_queues #(
  parameter int unsigned QUEUE_DEPTH = mtmq_pkg::DefQueueDepth,
  parameter int unsigned HANDLE_BITS = mtmq_pkg::DefHandleBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       op_i,
  input  logic [mtmq_pkg::TagBits-1:0]     tag_i,
  input  logic [mtmq_pkg::TagBits-1:0]     tag_select_i,
  input  logic [HANDLE_BITS-1:0]           handle_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic                             matched_o,
  output logic [HANDLE_BITS-1:0]           found_handle_o,
  output logic [mtmq_pkg::TagBits-1:0]     found_tag_o
);
  import mtmq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned UW = TagBits + HANDLE_BITS;
  localparam int unsigned PW = 2 * TagBits + HANDLE_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e                 state_q;
  op_e                    op_q;
  logic [TagBits-1:0]     tag_q, sel_q;
  logic [HANDLE_BITS-1:0] hnd_q;
  logic [CW-1:0]          ucnt_q, pcnt_q, ptr_q;
  logic                   chk_q, shv_q;
  logic [AW-1:0]          chk_idx_q, wr_idx_q;
  status_e                res_status_q;
  logic                   res_matched_q;
  logic [HANDLE_BITS-1:0] res_handle_q;
  logic [TagBits-1:0]     res_tag_q;
  logic                   out_valid_q;
  status_e                out_status_q;
  logic                   out_matched_q;
  logic [HANDLE_BITS-1:0] out_handle_q;
  logic [TagBits-1:0]     out_tag_q;

  logic          u_we, p_we;
  logic [AW-1:0] u_waddr, p_waddr;
  logic [UW-1:0] u_wdata, u_rdata;
  logic [PW-1:0] p_wdata, p_rdata;
  logic          in_fire, is_cancel, match_w;
  logic [CW-1:0] scan_cnt;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_cancel  = (op_q == OP_CANCEL);
  assign scan_cnt   = is_cancel ? pcnt_q : ucnt_q;

  // Shared comparator: masked tag compare for a search, handle compare for a cancel.
  assign match_w = is_cancel ? (p_rdata[HANDLE_BITS-1:0] == hnd_q)
                             : (((tag_q ^ u_rdata[UW-1:HANDLE_BITS]) & sel_q) == '0);

  // RAM write ports: appends and the compaction moves.
  always_comb begin
    u_we    = 1'b0;
    u_waddr = ucnt_q[AW-1:0];
    u_wdata = {tag_i, handle_i};
    p_we    = 1'b0;
    p_waddr = pcnt_q[AW-1:0];
    p_wdata = {tag_q, sel_q, hnd_q};
    if (in_fire && (op_e'(op_i) == OP_ARRIVE) && (ucnt_q != CW'(QUEUE_DEPTH))) begin
      u_we = 1'b1;
    end
    if (state_q == S_SCAN && !(chk_q && match_w) && (ptr_q == scan_cnt) &&
        (op_q == OP_POST) && (pcnt_q != CW'(QUEUE_DEPTH))) begin
      p_we = 1'b1;
    end
    if (state_q == S_SHIFT && shv_q) begin
      if (is_cancel) begin
        p_we    = 1'b1;
        p_waddr = wr_idx_q;
        p_wdata = p_rdata;
      end else begin
        u_we    = 1'b1;
        u_waddr = wr_idx_q;
        u_wdata = u_rdata;
      end
    end
  end

  mtmq_ram #(.Width(UW), .Depth(QUEUE_DEPTH)) u_unexp_ram (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (u_waddr),
    .wdata_i (u_wdata),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (u_rdata)
  );

  mtmq_ram #(.Width(PW), .Depth(QUEUE_DEPTH)) u_posted_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (p_rdata)
  );

  // Sequencer with request, result and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ucnt_q      <= '0;
      pcnt_q      <= '0;
      ptr_q       <= '0;
      chk_q       <= 1'b0;
      shv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            op_q          <= op_e'(op_i);
            tag_q         <= tag_i;
            sel_q         <= tag_select_i;
            hnd_q         <= handle_i;
            res_status_q  <= ST_OK;
            res_matched_q <= 1'b0;
            res_handle_q  <= '0;
            res_tag_q     <= '0;
            ptr_q         <= '0;
            chk_q         <= 1'b0;
            if (op_e'(op_i) == OP_ARRIVE) begin
              if (ucnt_q == CW'(QUEUE_DEPTH)) begin
                res_status_q <= ST_FULL;
              end else begin
                ucnt_q <= ucnt_q + 1'b1;
              end
              state_q <= S_DONE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (chk_q && match_w) begin
            // Oldest matching entry found.
            if (!is_cancel) begin
              res_matched_q <= 1'b1;
              res_handle_q  <= u_rdata[HANDLE_BITS-1:0];
              res_tag_q     <= u_rdata[UW-1:HANDLE_BITS];
            end
            if (op_q == OP_PROBE) begin
              state_q <= S_DONE;
            end else begin
              ptr_q   <= {1'b0, chk_idx_q} + 1'b1;
              shv_q   <= 1'b0;
              state_q <= S_SHIFT;
            end
          end else if (ptr_q == scan_cnt) begin
            // Searched every entry without a match.
            unique case (op_q)
              OP_PROBE:  res_status_q <= ST_NO_MATCH;
              OP_CANCEL: res_status_q <= ST_NOT_FOUND;
              default: begin
                if (pcnt_q == CW'(QUEUE_DEPTH)) begin
                  res_status_q <= ST_FULL;
                end else begin
                  res_status_q <= ST_NO_MATCH;
                  pcnt_q       <= pcnt_q + 1'b1;
                end
              end
            endcase
            state_q <= S_DONE;
          end else begin
            chk_q     <= 1'b1;
            chk_idx_q <= ptr_q[AW-1:0];
            ptr_q     <= ptr_q + 1'b1;
          end
        end
        S_SHIFT: begin
          // Move each younger entry down one place.
          if (ptr_q != scan_cnt) begin
            shv_q    <= 1'b1;
            wr_idx_q <= ptr_q[AW-1:0] - 1'b1;
            ptr_q    <= ptr_q + 1'b1;
          end else if (shv_q) begin
            shv_q <= 1'b0;
          end else begin
            if (is_cancel) begin
              pcnt_q <= pcnt_q - 1'b1;
            end else begin
              ucnt_q <= ucnt_q - 1'b1;
            end
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q   <= 1'b1;
            out_status_q  <= res_status_q;
            out_matched_q <= res_matched_q;
            out_handle_q  <= res_handle_q;
            out_tag_q     <= res_tag_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign matched_o      = out_matched_q;
  assign found_handle_o = out_handle_q;
  assign found_tag_o    = out_tag_q;

endmodule

[rtl/core/mtmq_checker.sv]
`timescale 1ns / 1ps
module mtmq_checker #(
  parameter int unsigned HANDLE_BITS = mtmq_pkg::DefHandleBits
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [1:0]                   status_o,
  input logic                         matched_o,
  input logic [HANDLE_BITS-1:0]       found_handle_o,
  input logic [mtmq_pkg::TagBits-1:0] found_tag_o
);
  import mtmq_pkg::*;

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(found_tag_o) && $stable(found_handle_o))
    else $error("stalled result changed");

  // A match always reports status ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && matched_o |-> status_o == ST_OK)
    else $error("match with bad status");

  // Without a match the found fields are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !matched_o |-> found_handle_o == '0 && found_tag_o == '0)
    else $error("found fields set without a match");

  // Each request keeps the block busy: in_ready_o drops once a request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken on back-to-back cycles");

endmodule

bind masked_tag_match_queues mtmq_checker #(.HANDLE_BITS(HANDLE_BITS)) u_mtmq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .matched_o      (matched_o),
  .found_handle_o (found_handle_o),
  .found_tag_o    (found_tag_o)
);
